// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/cpsel_pkg.sv =====
`default_nettype none

package cpsel_pkg;

  localparam int DATA_WIDTH_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  // Guard bits below the input LSB on the rotation datapath.
  localparam int GUARD_BITS       = 16;
  // Angle accumulator width: pi = 2^31, sum stays below 2^32 in magnitude.
  localparam int ANGLE_W          = 34;
  localparam logic [31:0] ANGLE_HALF_PI = 32'd1073741824;

  typedef enum logic [1:0] {
    MODE_PHASE = 2'd0,
    MODE_MAG   = 2'd1,
    MODE_REAL  = 2'd2,
    MODE_IMAG  = 2'd3
  } mode_e;

  // atan(2^-i) with pi = 2^31
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10679838;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41722;
      5'd15:   val = 32'd20861;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2608;
      5'd19:   val = 32'd1304;
      5'd20:   val = 32'd652;
      5'd21:   val = 32'd326;
      5'd22:   val = 32'd163;
      5'd23:   val = 32'd81;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cpsel_prep.sv =====
`default_nettype none

module cpsel_prep #(
  parameter int DATA_WIDTH = cpsel_pkg::DATA_WIDTH_DEF,
  parameter int XW         = DATA_WIDTH + cpsel_pkg::GUARD_BITS + 3
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  valid_i,
  output logic                                       ready_o,
  input  wire logic signed [DATA_WIDTH-1:0]          re_i,
  input  wire logic signed [DATA_WIDTH-1:0]          im_i,
  input  wire cpsel_pkg::mode_e                      mode_i,
  output logic                                       valid_o,
  input  wire logic                                  ready_i,
  output logic signed [XW-1:0]                       x_o,
  output logic signed [XW-1:0]                       y_o,
  output logic signed [cpsel_pkg::ANGLE_W-1:0]       z_o,
  output logic [2*DATA_WIDTH-1:0]                    rad_o,
  output logic [DATA_WIDTH-1:0]                      pass_o,
  output logic                                       zero_o,
  output cpsel_pkg::mode_e                           mode_o
);

  localparam int DW = DATA_WIDTH;
  localparam int GB = cpsel_pkg::GUARD_BITS;
  localparam int ZW = cpsel_pkg::ANGLE_W;
  localparam logic signed [ZW-1:0] HALF_PI =
    $signed({{(ZW-32){1'b0}}, cpsel_pkg::ANGLE_HALF_PI});

  logic                    vld_a_q, vld_b_q;
  logic                    rdy_a, rdy_b;
  logic signed [XW-1:0]    xs, ys;
  logic signed [XW-1:0]    x_a_d, y_a_d, x_a_q, y_a_q, x_b_q, y_b_q;
  logic signed [ZW-1:0]    z_a_d, z_a_q, z_b_q;
  logic signed [2*DW-1:0]  sqr_d, sqi_d;
  logic [2*DW-1:0]         sqr_a_q, sqi_a_q, rad_b_q;
  logic [DW-1:0]           pass_a_q, pass_b_q;
  logic                    zero_a_q, zero_b_q;
  cpsel_pkg::mode_e        mode_a_q, mode_b_q;

  assign rdy_b   = !vld_b_q || ready_i;
  assign rdy_a   = !vld_a_q || rdy_b;
  assign ready_o = rdy_a;

  assign xs = $signed({{(XW-DW-GB){re_i[DW-1]}}, re_i, {GB{1'b0}}});
  assign ys = $signed({{(XW-DW-GB){im_i[DW-1]}}, im_i, {GB{1'b0}}});

  // Fold the left half-plane into the right one by a quarter turn.
  always_comb begin
    x_a_d = xs;
    y_a_d = ys;
    z_a_d = '0;
    if (re_i[DW-1]) begin
      if (!im_i[DW-1]) begin
        x_a_d = ys;
        y_a_d = -xs;
        z_a_d = HALF_PI;
      end else begin
        x_a_d = -ys;
        y_a_d = xs;
        z_a_d = -HALF_PI;
      end
    end
  end

  assign sqr_d = re_i * re_i;
  assign sqi_d = im_i * im_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (rdy_a) vld_a_q <= valid_i;
      if (rdy_b) vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      x_a_q    <= x_a_d;
      y_a_q    <= y_a_d;
      z_a_q    <= z_a_d;
      sqr_a_q  <= sqr_d;
      sqi_a_q  <= sqi_d;
      pass_a_q <= (mode_i == cpsel_pkg::MODE_REAL) ? re_i : im_i;
      zero_a_q <= (re_i == '0) && (im_i == '0);
      mode_a_q <= mode_i;
    end
    if (rdy_b && vld_a_q) begin
      x_b_q    <= x_a_q;
      y_b_q    <= y_a_q;
      z_b_q    <= z_a_q;
      rad_b_q  <= sqr_a_q + sqi_a_q;
      pass_b_q <= pass_a_q;
      zero_b_q <= zero_a_q;
      mode_b_q <= mode_a_q;
    end
  end

  assign valid_o = vld_b_q;
  assign x_o     = x_b_q;
  assign y_o     = y_b_q;
  assign z_o     = z_b_q;
  assign rad_o   = rad_b_q;
  assign pass_o  = pass_b_q;
  assign zero_o  = zero_b_q;
  assign mode_o  = mode_b_q;

endmodule

`default_nettype wire

// ===== rtl/core/cpsel_cell.sv =====
`default_nettype none

module cpsel_cell #(
  parameter int DATA_WIDTH   = cpsel_pkg::DATA_WIDTH_DEF,
  parameter int CORDIC_STEPS = cpsel_pkg::CORDIC_STEPS_DEF,
  parameter int STEP         = 0,
  parameter int XW           = DATA_WIDTH + cpsel_pkg::GUARD_BITS + 3
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  output logic                                   ready_o,
  input  wire logic signed [XW-1:0]              x_i,
  input  wire logic signed [XW-1:0]              y_i,
  input  wire logic signed [cpsel_pkg::ANGLE_W-1:0] z_i,
  input  wire logic [2*DATA_WIDTH-1:0]           rad_i,
  input  wire logic [DATA_WIDTH+1:0]             rem_i,
  input  wire logic [DATA_WIDTH-1:0]             root_i,
  input  wire logic [DATA_WIDTH-1:0]             pass_i,
  input  wire logic                              zero_i,
  input  wire cpsel_pkg::mode_e                  mode_i,
  output logic                                   valid_o,
  input  wire logic                              ready_i,
  output logic signed [XW-1:0]                   x_o,
  output logic signed [XW-1:0]                   y_o,
  output logic signed [cpsel_pkg::ANGLE_W-1:0]   z_o,
  output logic [2*DATA_WIDTH-1:0]                rad_o,
  output logic [DATA_WIDTH+1:0]                  rem_o,
  output logic [DATA_WIDTH-1:0]                  root_o,
  output logic [DATA_WIDTH-1:0]                  pass_o,
  output logic                                   zero_o,
  output cpsel_pkg::mode_e                       mode_o
);

  localparam int DW = DATA_WIDTH;
  localparam int ZW = cpsel_pkg::ANGLE_W;
  localparam bit DO_ROT  = (STEP < CORDIC_STEPS) && (STEP < cpsel_pkg::ATAN_ENTRIES);
  localparam bit DO_SQRT = (STEP < DW);
  localparam logic signed [ZW-1:0] ANG =
    $signed({{(ZW-32){1'b0}}, cpsel_pkg::atan_lut(5'(STEP))});

  logic                    vld_q;
  logic signed [XW-1:0]    dx, dy, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0]    z_d, z_q;
  logic [DW+3:0]           rem_sh, trial, diff;
  logic [DW+1:0]           rem_d, rem_q;
  logic [DW-1:0]           root_d, root_q, pass_q;
  logic [2*DW-1:0]         rad_d, rad_q;
  logic                    zero_q;
  cpsel_pkg::mode_e        mode_q;

  assign ready_o = !vld_q || ready_i;

  // One vectoring rotation: drive y toward zero.
  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_comb begin
    x_d = x_i;
    y_d = y_i;
    z_d = z_i;
    if (DO_ROT) begin
      if (!y_i[XW-1]) begin
        x_d = x_i + dx;
        y_d = y_i - dy;
        z_d = z_i + ANG;
      end else begin
        x_d = x_i - dx;
        y_d = y_i + dy;
        z_d = z_i - ANG;
      end
    end
  end

  // One restoring square-root digit: bring down two radicand bits.
  assign rem_sh = {rem_i, rad_i[2*DW-1 -: 2]};
  assign trial  = {2'b00, root_i, 2'b01};
  assign diff   = rem_sh - trial;

  always_comb begin
    rem_d  = rem_i;
    root_d = root_i;
    rad_d  = rad_i;
    if (DO_SQRT) begin
      rad_d = {rad_i[2*DW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = diff[DW+1:0];
        root_d = {root_i[DW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[DW+1:0];
        root_d = {root_i[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      pass_q <= pass_i;
      zero_q <= zero_i;
      mode_q <= mode_i;
    end
  end

  assign valid_o = vld_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign pass_o  = pass_q;
  assign zero_o  = zero_q;
  assign mode_o  = mode_q;

endmodule

`default_nettype wire

// ===== rtl/core/cpsel_out.sv =====
`default_nettype none

module cpsel_out #(
  parameter int DATA_WIDTH = cpsel_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 valid_i,
  output logic                                      ready_o,
  input  wire logic signed [cpsel_pkg::ANGLE_W-1:0] z_i,
  input  wire logic [DATA_WIDTH+1:0]                rem_i,
  input  wire logic [DATA_WIDTH-1:0]                root_i,
  input  wire logic [DATA_WIDTH-1:0]                pass_i,
  input  wire logic                                 zero_i,
  input  wire cpsel_pkg::mode_e                     mode_i,
  output logic                                      valid_o,
  input  wire logic                                 ready_i,
  output logic signed [DATA_WIDTH:0]                value_o
);

  localparam int DW  = DATA_WIDTH;
  localparam int ZW  = cpsel_pkg::ANGLE_W;
  localparam int ASH = 32 - DW;
  localparam logic signed [ZW-1:0] HALF = ZW'((64'd1 << ASH) >> 1);

  logic                 vld_q;
  logic signed [ZW-1:0] z_rnd;
  logic [DW-1:0]        phase, mag;
  logic [DW:0]          value_d, value_q;

  assign ready_o = !vld_q || ready_i;

  // Round half up to DW-1 fractional bits of pi, then wrap.
  assign z_rnd = (z_i + HALF) >>> ASH;
  assign phase = zero_i ? '0 : z_rnd[DW-1:0];
  // Round the root to nearest: remainder above root means past the half.
  assign mag   = root_i + DW'(rem_i > {2'b00, root_i});

  always_comb begin
    case (mode_i)
      cpsel_pkg::MODE_PHASE: value_d = {phase[DW-1], phase};
      cpsel_pkg::MODE_MAG:   value_d = {1'b0, mag};
      default:               value_d = {pass_i[DW-1], pass_i};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      value_q <= value_d;
    end
  end

  assign valid_o = vld_q;
  assign value_o = $signed(value_q);

endmodule

`default_nettype wire

// ===== rtl/core/complex_to_polar_component_select_core.sv =====
// Pipeline: prep, CELLS cells, output; CELLS = max(DATA_WIDTH, min(CORDIC_STEPS, 24)).
// Throughput: one transaction per cycle unless out_ready_i stalls; each pipeline stage
// fills a bubble on its own, so input stays ready while any stage, including the output register, is empty.
// Reset (rst_ni, async, active low): clears all stage valid bits and sets the mode
// register to phase; datapath registers are not reset.
`default_nettype none
`include "assert_macros.svh"

module complex_to_polar_component_select_core #(
  parameter int DATA_WIDTH   = cpsel_pkg::DATA_WIDTH_DEF,
  parameter int CORDIC_STEPS = cpsel_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         conversion_mode_we_i,
  input  wire logic [1:0]                   conversion_mode_i,
  // input samples
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [DATA_WIDTH-1:0] real_part_i,
  input  wire logic signed [DATA_WIDTH-1:0] imag_part_i,
  // results
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [DATA_WIDTH:0]        converted_value_o
);

  localparam int DW    = DATA_WIDTH;
  localparam int XW    = DW + cpsel_pkg::GUARD_BITS + 3;
  localparam int ZW    = cpsel_pkg::ANGLE_W;
  localparam int ROTS  = (CORDIC_STEPS < cpsel_pkg::ATAN_ENTRIES) ?
                         CORDIC_STEPS : cpsel_pkg::ATAN_ENTRIES;
  // Each cell carries at most one rotation and one root digit.
  localparam int CELLS = (DW > ROTS) ? DW : ROTS;

  cpsel_pkg::mode_e mode_q;

  // Chain links: index k feeds cell k, index CELLS feeds the output stage.
  logic                   vld_w  [CELLS+1];
  logic                   rdy_w  [CELLS+1];
  logic signed [XW-1:0]   x_w    [CELLS+1];
  logic signed [XW-1:0]   y_w    [CELLS+1];
  logic signed [ZW-1:0]   z_w    [CELLS+1];
  logic [2*DW-1:0]        rad_w  [CELLS+1];
  logic [DW+1:0]          rem_w  [CELLS+1];
  logic [DW-1:0]          root_w [CELLS+1];
  logic [DW-1:0]          pass_w [CELLS+1];
  logic                   zero_w [CELLS+1];
  cpsel_pkg::mode_e       mode_w [CELLS+1];

  // Hold the mode; the user must write it only while the pipeline is empty (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cpsel_pkg::MODE_PHASE;
    end else if (conversion_mode_we_i) begin
      mode_q <= cpsel_pkg::mode_e'(conversion_mode_i);
    end
  end

  // Quadrant fold, squares, then the sum of squares.
  cpsel_prep #(
    .DATA_WIDTH (DW),
    .XW         (XW)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .re_i    (real_part_i),
    .im_i    (imag_part_i),
    .mode_i  (mode_q),
    .valid_o (vld_w[0]),
    .ready_i (rdy_w[0]),
    .x_o     (x_w[0]),
    .y_o     (y_w[0]),
    .z_o     (z_w[0]),
    .rad_o   (rad_w[0]),
    .pass_o  (pass_w[0]),
    .zero_o  (zero_w[0]),
    .mode_o  (mode_w[0])
  );

  // Root and remainder start empty at the head of the chain.
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    cpsel_cell #(
      .DATA_WIDTH   (DW),
      .CORDIC_STEPS (ROTS),
      .STEP         (k),
      .XW           (XW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_w[k]),
      .ready_o (rdy_w[k]),
      .x_i     (x_w[k]),
      .y_i     (y_w[k]),
      .z_i     (z_w[k]),
      .rad_i   (rad_w[k]),
      .rem_i   (rem_w[k]),
      .root_i  (root_w[k]),
      .pass_i  (pass_w[k]),
      .zero_i  (zero_w[k]),
      .mode_i  (mode_w[k]),
      .valid_o (vld_w[k+1]),
      .ready_i (rdy_w[k+1]),
      .x_o     (x_w[k+1]),
      .y_o     (y_w[k+1]),
      .z_o     (z_w[k+1]),
      .rad_o   (rad_w[k+1]),
      .rem_o   (rem_w[k+1]),
      .root_o  (root_w[k+1]),
      .pass_o  (pass_w[k+1]),
      .zero_o  (zero_w[k+1]),
      .mode_o  (mode_w[k+1])
    );
  end

  // Round, select by mode, and register the result.
  cpsel_out #(
    .DATA_WIDTH (DW)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_w[CELLS]),
    .ready_o (rdy_w[CELLS]),
    .z_i     (z_w[CELLS]),
    .rem_i   (rem_w[CELLS]),
    .root_i  (root_w[CELLS]),
    .pass_i  (pass_w[CELLS]),
    .zero_i  (zero_w[CELLS]),
    .mode_i  (mode_w[CELLS]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .value_o (converted_value_o)
  );

  // Results are never left in x, y, rad after the last cell.

  // An empty output register lets ready ripple all the way to the input.
  `ASSERT_IMP(a_ready_when_out_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)
  // The output register only fills from the last cell.
  `ASSERT_NXT(a_out_from_chain, clk_i, rst_ni, !out_valid_o && !vld_w[CELLS], !out_valid_o)
  // Magnitude never reaches the top bit; other modes are sign-extended.
  `ASSERT_IMP(a_top_bits, clk_i, rst_ni, out_valid_o && converted_value_o[DW],
              converted_value_o[DW-1])

endmodule

`default_nettype wire
